[hdl/json_string_unescape_utf8_defines.svh]
// -----------------------------------------------------------------------------
// json string unescape assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// -----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define JSU_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define JSU_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hdl/jsu_pkg.sv]
// -----------------------------------------------------------------------------
// jsu_pkg
// types, status codes and utf-8 helpers for the json string unescaper
// -----------------------------------------------------------------------------
package jsu_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_ESC_END   = 3'd1;
	localparam status_t ST_BAD_ESC   = 3'd2;
	localparam status_t ST_BAD_HEX   = 3'd3;
	localparam status_t ST_BAD_SURR  = 3'd4;
	localparam status_t ST_UNTERM    = 3'd5;

	localparam logic [20:0] CP_MAX1  = 21'h00007F;
	localparam logic [20:0] CP_MAX2  = 21'h0007FF;
	localparam logic [20:0] CP_MAX3  = 21'h00FFFF;
	localparam logic [15:0] HI_FIRST = 16'hD800;
	localparam logic [15:0] HI_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_FIRST = 16'hDC00;
	localparam logic [15:0] LO_LAST  = 16'hDFFF;
	localparam logic [10:0] PLANE_OFS = 11'h040;

	// one input transaction
	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_start;
		logic       text_end;
	} item_t;

	// all results caused by one input transaction
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nb;
		logic            fin;
		status_t         st;
	} burst_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} nib_t;

	function automatic nib_t hex_nib(input logic [7:0] c);
		nib_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= "0" && c <= "9") begin
			r.val = c[3:0];
		end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
			r.val = c[3:0] + 4'd9;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic burst_t utf8_burst(input logic [20:0] cp);
		burst_t b;
		b.bytes = '0;
		b.fin   = 1'b0;
		b.st    = ST_OK;
		if (cp <= CP_MAX1) begin
			b.nb       = 3'd1;
			b.bytes[0] = cp[7:0];
		end else if (cp <= CP_MAX2) begin
			b.nb       = 3'd2;
			b.bytes[0] = {3'b110, cp[10:6]};
			b.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= CP_MAX3) begin
			b.nb       = 3'd3;
			b.bytes[0] = {4'b1110, cp[15:12]};
			b.bytes[1] = {2'b10, cp[11:6]};
			b.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			b.nb       = 3'd4;
			b.bytes[0] = {5'b11110, cp[20:18]};
			b.bytes[1] = {2'b10, cp[17:12]};
			b.bytes[2] = {2'b10, cp[11:6]};
			b.bytes[3] = {2'b10, cp[5:0]};
		end
		return b;
	endfunction

endpackage

[hdl/json_string_unescape_utf8.sv]
// -----------------------------------------------------------------------------
// json_string_unescape_utf8
// json string body unescaper with utf-8 output, one body byte per transaction
// -----------------------------------------------------------------------------
// slave side takes one string body byte per transaction, starting after the
// opening quote; tuser marks the first byte of a string, tlast the last byte
// of the whole text. master side gives one result per transaction: a decoded
// utf-8 byte (tuser high) or the final result of the string (tlast high)
// carrying the status code in tdata.
// an input byte passes the input register, then the burst register that feeds the
// output. it takes one input byte per cycle while each byte gives at most one
// result and the master side does not stall; a byte that yields more than one
// result (up to four utf-8 bytes plus the final result) holds the burst
// register until the single output port has sent them all. the next input
// byte is taken in the same cycle as the last result of a burst.
// reset clears the decoder to idle and empties both registers; bytes before a
// string start are dropped. a stalled master side holds the current result and
// the input register fills, after which s_tready drops.
// -----------------------------------------------------------------------------
module json_string_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tuser,   // [0] string_start
	input  logic        s_tlast,   // text_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, rest zero
	output logic        m_tuser,   // [0] has_byte
	output logic        m_tlast    // string_done
);
	import jsu_pkg::*;

	item_t   in_item, item_s1;
	logic    v_s1, adv;
	burst_t  burst;
	logic [7:0] out_byte;
	status_t status;

	assign in_item.in_byte      = s_tdata;
	assign in_item.string_start = s_tuser;
	assign in_item.text_end     = s_tlast;

	jsu_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.v_s1     (v_s1),
		.item_s1  (item_s1),
		.adv      (adv)
	);

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item_s1 (item_s1),
		.adv     (adv),
		.burst   (burst)
	);

	jsu_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.burst       (burst),
		.adv         (adv),
		.m_valid     (m_tvalid),
		.m_ready     (m_tready),
		.out_byte    (out_byte),
		.has_byte    (m_tuser),
		.string_done (m_tlast),
		.status      (status)
	);

	assign m_tdata = {5'd0, status, out_byte};

endmodule

[hdl/jsu_in_reg.sv]
// -----------------------------------------------------------------------------
// jsu_in_reg
// input register stage, holds one transaction until the decoder takes it
// -----------------------------------------------------------------------------
module jsu_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  jsu_pkg::item_t in_item,
	output logic           v_s1,
	output jsu_pkg::item_t item_s1,
	input  logic           adv
);
	import jsu_pkg::*;

	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[hdl/jsu_decode.sv]
// -----------------------------------------------------------------------------
// jsu_decode
// escape state machine, turns one body byte into its burst of results
// -----------------------------------------------------------------------------
module jsu_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  jsu_pkg::item_t  item_s1,
	input  logic            adv,
	output jsu_pkg::burst_t burst
);
	import jsu_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_TEXT, PH_ESC, PH_HEX, PH_PBS, PH_PU, PH_HEX2
	} phase_t;

	phase_t      phase_q, ph, ph_n;
	logic [1:0]  hex_q, hc, hc_n;
	logic [11:0] acc_q, acc, acc_n;
	logic [9:0]  hh_q, hh, hh_n;
	logic [15:0] acc_full;
	logic [10:0] plane;
	logic [7:0]  c;
	logic        last, fin, tail;
	status_t     st;
	nib_t        nb;
	burst_t      b;

	always_comb begin
		c    = item_s1.in_byte;
		last = item_s1.text_end;
		ph   = item_s1.string_start ? PH_TEXT : phase_q;
		hc   = item_s1.string_start ? 2'd0 : hex_q;
		acc  = item_s1.string_start ? 12'd0 : acc_q;
		hh   = item_s1.string_start ? 10'd0 : hh_q;

		nb       = hex_nib(c);
		acc_full = {acc, nb.val};
		plane    = {1'b0, hh} + PLANE_OFS;

		ph_n  = ph;
		hc_n  = hc;
		acc_n = acc;
		hh_n  = hh;
		fin   = 1'b0;
		tail  = 1'b0;
		st    = ST_OK;
		b     = '0;

		case (ph)
			PH_TEXT: begin
				if (c == "\"") begin
					fin = 1'b1;
				end else if (c == "\\") begin
					ph_n = PH_ESC;
					if (last) begin
						fin = 1'b1;
						st  = ST_ESC_END;
					end
				end else begin
					b.nb       = 3'd1;
					b.bytes[0] = c;
					tail       = 1'b1;
				end
			end
			PH_ESC: begin
				ph_n = PH_TEXT;
				b.nb = 3'd1;
				tail = 1'b1;
				case (c)
					"\"", "\\", "/": b.bytes[0] = c;
					"b": b.bytes[0] = 8'h08;
					"f": b.bytes[0] = 8'h0C;
					"n": b.bytes[0] = 8'h0A;
					"r": b.bytes[0] = 8'h0D;
					"t": b.bytes[0] = 8'h09;
					"u": begin
						b.nb  = 3'd0;
						tail  = 1'b0;
						ph_n  = PH_HEX;
						hc_n  = 2'd0;
						acc_n = 12'd0;
						if (last) begin
							fin = 1'b1;
							st  = ST_BAD_HEX;
						end
					end
					default: begin
						b.nb = 3'd0;
						tail = 1'b0;
						fin  = 1'b1;
						st   = ST_BAD_ESC;
					end
				endcase
			end
			PH_HEX, PH_HEX2: begin
				if (!nb.ok) begin
					fin = 1'b1;
					st  = ST_BAD_HEX;
				end else if (hc != 2'd3) begin
					hc_n  = hc + 2'd1;
					acc_n = acc_full[11:0];
					if (last) begin
						fin = 1'b1;
						st  = (ph == PH_HEX) ? ST_BAD_HEX : ST_BAD_SURR;
					end
				end else begin
					hc_n = 2'd0;
					if (ph == PH_HEX && acc_full >= HI_FIRST && acc_full <= HI_LAST) begin
						hh_n = acc_full[9:0];
						ph_n = PH_PBS;
						if (last) begin
							fin = 1'b1;
							st  = ST_BAD_SURR;
						end
					end else if (ph == PH_HEX && acc_full >= LO_FIRST && acc_full <= LO_LAST) begin
						fin = 1'b1;
						st  = ST_BAD_SURR;
					end else if (ph == PH_HEX) begin
						ph_n = PH_TEXT;
						b    = utf8_burst({5'd0, acc_full});
						tail = 1'b1;
					end else if (acc_full < LO_FIRST || acc_full > LO_LAST) begin
						fin = 1'b1;
						st  = ST_BAD_SURR;
					end else begin
						ph_n = PH_TEXT;
						b    = utf8_burst({plane, acc_full[9:0]});
						tail = 1'b1;
					end
				end
			end
			PH_PBS: begin
				ph_n = PH_PU;
				if (c != "\\" || last) begin
					fin = 1'b1;
					st  = ST_BAD_SURR;
				end
			end
			PH_PU: begin
				ph_n  = PH_HEX2;
				hc_n  = 2'd0;
				acc_n = 12'd0;
				if (c != "u" || last) begin
					fin = 1'b1;
					st  = ST_BAD_SURR;
				end
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		// string left open on the last byte of the text
		if (tail && last) begin
			fin = 1'b1;
			st  = ST_UNTERM;
		end

		b.fin = fin;
		b.st  = st;
		burst = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q   <= 2'd0;
			acc_q   <= 12'd0;
			hh_q    <= 10'd0;
		end else if (adv) begin
			if (fin) begin
				phase_q <= PH_IDLE;
				hex_q   <= 2'd0;
				acc_q   <= 12'd0;
				hh_q    <= 10'd0;
			end else begin
				phase_q <= ph_n;
				hex_q   <= hc_n;
				acc_q   <= acc_n;
				hh_q    <= hh_n;
			end
		end
	end

endmodule

[hdl/jsu_emit.sv]
// -----------------------------------------------------------------------------
// jsu_emit
// result register, sends the bytes of one burst and its final result in order
// -----------------------------------------------------------------------------
module jsu_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_s1,
	input  jsu_pkg::burst_t burst,
	output logic            adv,
	output logic            m_valid,
	input  logic            m_ready,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic            string_done,
	output jsu_pkg::status_t status
);
	import jsu_pkg::*;

	`include "json_string_unescape_utf8_defines.svh"

	logic [3:0][7:0] bytes_q;
	logic [2:0]      nb_q;
	logic            fin_q;
	status_t         st_q;
	logic [2:0]      pos_q;
	logic [2:0]      total;
	logic            take;

	assign total    = nb_q + {2'd0, fin_q};
	assign m_valid  = (pos_q != total);
	// burst register frees up once its last result goes out
	assign take     = !m_valid || (m_ready && (pos_q + 3'd1 == total));
	assign adv      = v_s1 && take;

	assign has_byte    = (pos_q < nb_q);
	assign out_byte    = has_byte ? bytes_q[pos_q[1:0]] : 8'd0;
	assign string_done = !has_byte;
	assign status      = has_byte ? ST_OK : st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q  <= 3'd0;
			fin_q <= 1'b0;
			pos_q <= 3'd0;
		end else if (take) begin
			nb_q  <= adv ? burst.nb : 3'd0;
			fin_q <= adv ? burst.fin : 1'b0;
			pos_q <= 3'd0;
		end else if (m_ready) begin
			pos_q <= pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bytes_q <= burst.bytes;
			st_q    <= burst.st;
		end
	end

	`JSU_ASSERT_ALWAYS(a_pos_in_burst, pos_q <= total, "result position past end of burst")
	`JSU_ASSERT_ALWAYS(a_burst_size, total <= 3'd5, "burst holds more than five results")
	`JSU_ASSERT_IMP(a_byte_status, m_valid && has_byte, status == ST_OK,
		"byte result carries a nonzero status")
	`JSU_ASSERT_IMP(a_done_no_byte, m_valid && string_done, fin_q && pos_q == nb_q,
		"final result sent before all bytes of the burst")

endmodule

[verif/json_string_unescape_utf8_test.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// json_string_unescape_utf8_test
// feeds json string bodies byte by byte into the unescaper, with random gaps
// on both stream sides, and checks every decoded utf-8 byte and every final
// status against a behavioural decoder that is kept in step with the inputs
// -----------------------------------------------------------------------------
module json_string_unescape_utf8_test;

	import jsu_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 1000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned RANDOM_ITEMS = 24;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		D_IDLE, D_TEXT, D_ESC, D_HEX, D_PAIR_BS, D_PAIR_U, D_HEX2
	} dec_phase_t;

	typedef struct {
		logic [7:0] ch;
		logic       has;
		logic       done;
		status_t    st;
	} dec_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// behavioural decoder state
	dec_phase_t  dphase;
	int unsigned hex_n;
	logic [15:0] acc;
	logic [9:0]  hi10;

	dec_result_t decoded_q[$];
	logic [7:0]  text_q[$];

	int unsigned fail_cnt;
	int unsigned taken_cnt;
	int unsigned src_gap_max;
	int unsigned sink_gap_max;
	int unsigned hold_cycles;
	int unsigned idle_cnt;

	logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

	json_string_unescape_utf8 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------- decoder

	function automatic int hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	function automatic void clear_decoder();
		dphase = D_IDLE;
		hex_n  = 0;
		acc    = '0;
		hi10   = '0;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		dec_result_t r;
		r = '{b, 1'b1, 1'b0, ST_OK};
		decoded_q.insert(decoded_q.size(), r);
	endfunction

	function automatic void close_string(input status_t s);
		dec_result_t r;
		r = '{8'h00, 1'b0, 1'b1, s};
		decoded_q.insert(decoded_q.size(), r);
		clear_decoder();
	endfunction

	function automatic void push_code_point(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			push_byte(cp[7:0]);
		end else if (cp <= 21'h7FF) begin
			push_byte({3'b110, cp[10:6]});
			push_byte({2'b10, cp[5:0]});
		end else if (cp <= 21'hFFFF) begin
			push_byte({4'b1110, cp[15:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end else begin
			push_byte({5'b11110, cp[20:18]});
			push_byte({2'b10, cp[17:12]});
			push_byte({2'b10, cp[11:6]});
			push_byte({2'b10, cp[5:0]});
		end
	endfunction

	// returns 0 when the byte is dropped because no string is open
	function automatic bit decode_byte(input logic [7:0] c, input logic st, input logic tl);
		int d;
		if (st) begin
			clear_decoder();
			dphase = D_TEXT;
		end
		case (dphase)
			D_TEXT: begin
				if (c == CH_QUOTE) begin
					close_string(ST_OK);
					return 1'b1;
				end
				if (c == CH_BSLASH) begin
					if (tl) close_string(ST_ESC_END);
					else dphase = D_ESC;
					return 1'b1;
				end
				push_byte(c);
			end
			D_ESC: begin
				dphase = D_TEXT;
				case (c)
					CH_QUOTE, CH_BSLASH, "/": push_byte(c);
					"b": push_byte(8'h08);
					"f": push_byte(8'h0C);
					"n": push_byte(8'h0A);
					"r": push_byte(8'h0D);
					"t": push_byte(8'h09);
					"u": begin
						dphase = D_HEX;
						hex_n  = 0;
						acc    = '0;
						if (tl) close_string(ST_BAD_HEX);
						return 1'b1;
					end
					default: begin
						close_string(ST_BAD_ESC);
						return 1'b1;
					end
				endcase
			end
			D_HEX, D_HEX2: begin
				d = hex_val(c);
				if (d < 0) begin
					close_string(ST_BAD_HEX);
					return 1'b1;
				end
				acc = {acc[11:0], d[3:0]};
				hex_n++;
				if (hex_n < 4) begin
					if (tl) close_string(dphase == D_HEX ? ST_BAD_HEX : ST_BAD_SURR);
					return 1'b1;
				end
				hex_n = 0;
				if (dphase == D_HEX) begin
					if (acc >= HI_FIRST && acc <= HI_LAST) begin
						hi10   = acc[9:0];
						dphase = D_PAIR_BS;
						if (tl) close_string(ST_BAD_SURR);
						return 1'b1;
					end
					if (acc >= LO_FIRST && acc <= LO_LAST) begin
						close_string(ST_BAD_SURR);
						return 1'b1;
					end
					dphase = D_TEXT;
					push_code_point({5'b0, acc});
				end else begin
					if (acc < LO_FIRST || acc > LO_LAST) begin
						close_string(ST_BAD_SURR);
						return 1'b1;
					end
					dphase = D_TEXT;
					push_code_point(21'h10000 + {1'b0, hi10, acc[9:0]});
				end
			end
			D_PAIR_BS: begin
				if (c != CH_BSLASH) close_string(ST_BAD_SURR);
				else if (tl) close_string(ST_BAD_SURR);
				else dphase = D_PAIR_U;
				return 1'b1;
			end
			D_PAIR_U: begin
				if (c != "u" || tl) begin
					close_string(ST_BAD_SURR);
				end else begin
					dphase = D_HEX2;
					hex_n  = 0;
					acc    = '0;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
		if (tl) close_string(ST_UNTERM);
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- stream sides

	// called right after a rising edge; valid stays up between back-to-back bytes
	task automatic send_byte(input logic [7:0] b, input logic st, input logic tl);
		int unsigned gap;
		gap = $urandom_range(0, src_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= st;
		s_tlast  <= tl;
		do @(posedge clk); while (!s_tready);
		if (decode_byte(b, st, tl)) taken_cnt++;
	endtask

	task automatic source_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		source_idle();
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	// sends the gathered text as one string, start flag on its first byte
	task automatic send_text(input bit end_text);
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == 0, end_text && i == text_q.size() - 1);
		text_q.delete();
	endtask

	initial begin : result_sink
		int unsigned gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = (hold_cycles != 0) ? hold_cycles : $urandom_range(0, sink_gap_max);
			hold_cycles = 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		dec_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: result with nothing pending: expected none, got tdata %h tuser %b tlast %b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				w = decoded_q.pop_front();
				if (m_tdata[7:0] !== w.ch) begin
					fail_cnt++;
					$display("%0t: out_byte expected %h, got %h", $time, w.ch, m_tdata[7:0]);
				end
				if (m_tdata[10:8] !== w.st) begin
					fail_cnt++;
					$display("%0t: status expected %0d, got %0d", $time, w.st, m_tdata[10:8]);
				end
				if (m_tdata[15:11] !== 5'b0) begin
					fail_cnt++;
					$display("%0t: tdata padding expected 00, got %h", $time, m_tdata[15:11]);
				end
				if (m_tuser !== w.has) begin
					fail_cnt++;
					$display("%0t: has_byte expected %b, got %b", $time, w.has, m_tuser);
				end
				if (m_tlast !== w.done) begin
					fail_cnt++;
					$display("%0t: string_done expected %b, got %b", $time, w.done, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cnt <= 0;
		end else if (idle_cnt == IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	// ---------------------------------------------------------------- text builders

	function automatic void add_char(input logic [7:0] c);
		text_q.insert(text_q.size(), c);
	endfunction

	function automatic void add_str(input string s);
		for (int i = 0; i < s.len(); i++) add_char(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10) return "0" + v;
		if ($urandom_range(0, 1)) return "A" + v - 8'd10;
		return "a" + v - 8'd10;
	endfunction

	function automatic void add_u_escape(input logic [15:0] v);
		add_str("\\u");
		for (int i = 3; i >= 0; i--) add_char(hex_char(v[i*4 +: 4]));
	endfunction

	function automatic logic [15:0] rand_high();
		return HI_FIRST + 16'($urandom_range(0, 1023));
	endfunction

	function automatic logic [15:0] rand_low();
		return LO_FIRST + 16'($urandom_range(0, 1023));
	endfunction

	function automatic logic [7:0] rand_plain();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	function automatic bit is_escape_letter(input logic [7:0] c);
		foreach (esc_letters[i]) if (c == esc_letters[i]) return 1'b1;
		return c == "u";
	endfunction

	function automatic void add_bmp();
		logic [15:0] v;
		case ($urandom_range(0, 2))
			0: v = 16'($urandom_range(0, 16'h7F));
			1: v = 16'($urandom_range(16'h80, 16'h7FF));
			default: begin
				v = 16'($urandom_range(16'h800, 16'hFFFF));
				if (v >= HI_FIRST && v <= LO_LAST) v = v ^ 16'h4000;
			end
		endcase
		add_u_escape(v);
	endfunction

	// one element that ends the string with an error
	function automatic void add_broken();
		logic [7:0]  c;
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0: begin
				do c = 8'($urandom_range(0, 255)); while (is_escape_letter(c));
				add_char(CH_BSLASH);
				add_char(c);
			end
			1: begin
				add_str("\\u");
				repeat ($urandom_range(0, 3)) add_char(hex_char(4'($urandom_range(0, 15))));
				do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
				add_char(c);
			end
			2: add_u_escape(rand_low());
			3: begin
				add_u_escape(rand_high());
				do c = 8'($urandom_range(0, 255)); while (c == CH_BSLASH);
				add_char(c);
			end
			4: begin
				add_u_escape(rand_high());
				do c = 8'($urandom_range(0, 255)); while (c == "u");
				add_char(CH_BSLASH);
				add_char(c);
			end
			default: begin
				add_u_escape(rand_high());
				do v = 16'($urandom_range(0, 16'hFFFF)); while (v >= LO_FIRST && v <= LO_LAST);
				add_u_escape(v);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_idle_and_restart();
		src_gap_max  = 18;
		sink_gap_max = 18;
		// nothing open yet: all dropped
		send_byte("a", 1'b0, 1'b0);
		send_byte(CH_BSLASH, 1'b0, 1'b1);
		// empty string, then bytes after its end are dropped
		add_str("\"");
		send_text(1'b0);
		send_byte("z", 1'b0, 1'b0);
		send_byte(CH_QUOTE, 1'b0, 1'b1);
		// restart inside a \u escape, an escape and a surrogate pair
		add_str("ab\\u12");
		send_text(1'b0);
		add_str("c\\");
		send_text(1'b0);
		add_str("\\uD801\\");
		send_text(1'b0);
		add_str("d\"");
		send_text(1'b0);
		// one-byte text
		add_str("q");
		send_text(1'b1);
	endtask

	task automatic test_plain_and_escapes();
		src_gap_max  = 0;
		sink_gap_max = 0;
		add_char(8'h00);
		add_char(8'hFF);
		add_char(8'h7F);
		add_char(8'h80);
		add_str("\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
		send_text(1'b0);
		src_gap_max  = 18;
		sink_gap_max = 18;
		add_str("\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uAbCd");
		add_str("\\uD800\\uDC00\\udbff\\udfff\"");
		send_text(1'b0);
	endtask

	task automatic test_errors();
		add_str("ab\\");          send_text(1'b1);
		add_str("\\x");           send_text(1'b0);
		add_str("\\U");           send_text(1'b0);
		add_str("\\u12G4");       send_text(1'b0);
		add_str("\\u");           send_text(1'b1);
		add_str("\\u12");         send_text(1'b1);
		add_str("\\uDC00");       send_text(1'b0);
		add_str("\\uD800a");      send_text(1'b0);
		add_str("\\uDBFF\\x");    send_text(1'b0);
		add_str("\\uD800\\uD800"); send_text(1'b0);
		add_str("\\uD800\\u0041"); send_text(1'b0);
		add_str("\\uD800");       send_text(1'b1);
		add_str("\\uD800\\");     send_text(1'b1);
		add_str("\\uD800\\u");    send_text(1'b1);
		add_str("\\uD800\\uDC");  send_text(1'b1);
		add_str("\\uD800\\uDCZ0"); send_text(1'b0);
		add_str("xy");            send_text(1'b1);
		add_str("\\n");           send_text(1'b1);
		// four utf-8 bytes and the unterminated status from one byte
		add_str("\\uD83D\\uDE00"); send_text(1'b1);
	endtask

	task automatic test_output_stall();
		src_gap_max  = 0;
		sink_gap_max = 0;
		hold_cycles  = HOLD_CYCLES;
		repeat (2) begin
			add_u_escape(rand_high());
			add_u_escape(rand_low());
		end
		add_str("\"");
		send_text(1'b0);
		// sender waits for every result before going on
		wait_drained();
	endtask

	task automatic test_random_strings();
		int unsigned base;
		int unsigned k;
		int unsigned n_el;
		int unsigned cut;
		bit          broken;
		base = taken_cnt;
		while (taken_cnt < base + RANDOM_ITEMS) begin
			src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 18;
			sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
			text_q.delete();
			broken = 1'b0;
			n_el   = $urandom_range(1, 10);
			for (int i = 0; i < n_el && !broken; i++) begin
				k = $urandom_range(0, 99);
				if (k < 50) begin
					add_char(rand_plain());
				end else if (k < 65) begin
					add_char(CH_BSLASH);
					add_char(esc_letters[3'($urandom_range(0, 7))]);
				end else if (k < 80) begin
					add_bmp();
				end else if (k < 92) begin
					add_u_escape(rand_high());
					add_u_escape(rand_low());
				end else begin
					add_broken();
					broken = 1'b1;
				end
			end
			k = $urandom_range(0, 99);
			if (k < 70) begin
				add_str("\"");
				send_text($urandom_range(0, 9) == 0);
			end else if (k < 85) begin
				send_text(1'b1);
			end else begin
				// text ends at a random byte of the string
				cut = $urandom_range(1, text_q.size());
				while (text_q.size() > cut) void'(text_q.pop_back());
				send_text(1'b1);
			end
			// stray bytes between strings
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 19) == 0) wait_drained();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		s_tlast      = 1'b0;
		fail_cnt     = 0;
		taken_cnt    = 0;
		hold_cycles  = 0;
		src_gap_max  = 18;
		sink_gap_max = 18;
		clear_decoder();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_restart();
		test_plain_and_escapes();
		test_errors();
		test_output_stall();
		test_random_strings();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
